/* hdl/nscs_pkg.sv */
// ----------------------------------------------------------------------------
// nscs_pkg
// Shared widths, register indexes, reset values, codes and types of the
// network-synced clock scheduler.
// ----------------------------------------------------------------------------
package nscs_pkg;

  // Field widths
  localparam int TPS_W      = 10;
  localparam int ZONE_W     = 5;
  localparam int PORT_W     = 16;
  localparam int SEC_W      = 32;
  localparam int WAIT_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESYNC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENT_WAIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT      = 3'd6;

  // Reset values
  localparam logic [TPS_W-1:0]  RST_TICKS     = 10'd1000;
  localparam logic [ZONE_W-1:0] RST_ZONE      = 5'd7;
  localparam logic [SEC_W-1:0]  RST_RESYNC    = 32'd43200;
  localparam logic [WAIT_W-1:0] RST_RETRY     = 16'd2;
  localparam logic [WAIT_W-1:0] RST_SENT_WAIT = 16'd60;
  localparam logic [ADDR_W-1:0] RST_SERVER    = {8'd62, 8'd117, 8'd76, 8'd142};
  localparam logic [PORT_W-1:0] RST_PORT      = 16'd123;

  // Input and result kind codes
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;
  localparam logic RES_REQUEST = 1'b0;
  localparam logic RES_REFRESH = 1'b1;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Reciprocal constants for division by 60 and by 3
  localparam logic [SEC_W-1:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [SEC_W-1:0] DIV60_MUL     = 32'd2290649224;  // floor(2^37 / 60)
  localparam int               DIV60_SHIFT   = 37;
  localparam logic [SEC_W-1:0] DIV3_MUL      = 32'd1431655765;  // floor(2^32 / 3)
  localparam int               DIV3_SHIFT    = 32;
  localparam logic [6:0]       SIXTY         = 7'd60;
  localparam logic [2:0]       THREE         = 3'd3;

  // Configuration as seen by front and back
  typedef struct packed {
    logic [TPS_W-1:0]  ticks;
    logic [SEC_W-1:0]  zone_secs;
    logic [SEC_W-1:0]  resync;
    logic [WAIT_W-1:0] retry;
    logic [WAIT_W-1:0] sent_wait;
    logic [ADDR_W-1:0] server;
    logic [PORT_W-1:0] port;
  } nscs_cfg_t;

  // One queued job: which results to emit and the local time in seconds
  typedef struct packed {
    logic             req;
    logic             refr;
    logic [SEC_W-1:0] lt;
  } nscs_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_REQ,
    BK_MUL,
    BK_COR,
    BK_REF
  } nscs_bk_state_t;

  typedef enum logic [1:0] {
    STEP_SEC,
    STEP_MIN,
    STEP_HOUR
  } nscs_step_t;

  // Zone hours (signed) as seconds, wrapping modulo 2^32
  function automatic logic [SEC_W-1:0] zone_to_secs(input logic [ZONE_W-1:0] z);
    logic [SEC_W-1:0] sext;
    logic [2*SEC_W-1:0] prod;
    sext = {{(SEC_W-ZONE_W){z[ZONE_W-1]}}, z};
    prod = sext * SECS_PER_HOUR;
    return prod[SEC_W-1:0];
  endfunction

endpackage

/* hdl/nscs_if.sv */
// ----------------------------------------------------------------------------
// nscs_in_if / nscs_out_if
// Valid/ready channels of the clock scheduler: input items and results.
// ----------------------------------------------------------------------------
interface nscs_in_if import nscs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [PORT_W-1:0] dest_port;
  logic [SEC_W-1:0]  reply_seconds;
  logic              tx_ready;

  modport source (output valid, kind, dest_port, reply_seconds, tx_ready,
                  input ready);
  modport sink   (input valid, kind, dest_port, reply_seconds, tx_ready,
                  output ready);
endinterface

interface nscs_out_if import nscs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [ADDR_W-1:0] request_address;
  logic [HOUR_W-1:0] hours;
  logic [MIN_W-1:0]  minutes;
  logic [MIN_W-1:0]  seconds;
  logic              last;

  modport source (output valid, result_kind, request_address, hours, minutes,
                  seconds, last, input ready);
  modport sink   (input valid, result_kind, request_address, hours, minutes,
                  seconds, last, output ready);
endinterface

/* hdl/nscs_front.sv */
// ----------------------------------------------------------------------------
// nscs_front
// Accepts items, keeps the time base and schedule, and decides which
// results each item causes; pushes one job per item that has results.
// ----------------------------------------------------------------------------
module nscs_front import nscs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  nscs_cfg_t  cfg,
  nscs_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       job_push,
  output nscs_job_t  job
);

  logic [TPS_W-1:0] milli_r, milli_nxt;
  logic [SEC_W-1:0] sec_total_r, sec_total_nxt;
  logic [SEC_W-1:0] next_sync_r, next_sync_nxt;
  logic [SEC_W-1:0] offset_r, offset_nxt;
  logic [SEC_W-1:0] next_ref_r, next_ref_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_rdy_r, pend_rdy_nxt;

  logic             in_acc;
  logic             sync_due;
  logic             ref_due;
  logic             need_push;
  logic             eval_go;
  logic [TPS_W-1:0] milli_inc;

  // Evaluation of the pending item: sync and refresh checks
  assign sync_due  = (sec_total_r >= next_sync_r);
  assign ref_due   = (offset_r != '0) && (sec_total_r >= next_ref_r);
  assign need_push = sync_due || ref_due;
  assign eval_go   = pend_r && (!need_push || !q_full);

  // A new item may enter in the same cycle the pending one is evaluated
  assign in_ch.ready = !pend_r || eval_go;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign milli_inc   = milli_r + 1'b1;

  assign job_push = eval_go && need_push;
  assign job.req  = sync_due;
  assign job.refr = ref_due;
  assign job.lt   = offset_r + sec_total_r + cfg.zone_secs;

  // Next state: evaluation first, then the accepted item (reply wins)
  always_comb begin
    milli_nxt     = milli_r;
    sec_total_nxt = sec_total_r;
    next_sync_nxt = next_sync_r;
    offset_nxt    = offset_r;
    next_ref_nxt  = next_ref_r;
    pend_nxt      = pend_r;
    pend_rdy_nxt  = pend_rdy_r;

    if (eval_go) begin
      pend_nxt = 1'b0;
      if (sync_due) begin
        next_sync_nxt = sec_total_r + (pend_rdy_r ? SEC_W'(cfg.sent_wait)
                                                  : SEC_W'(cfg.retry));
      end
      if (ref_due) begin
        next_ref_nxt = sec_total_r + 1'b1;
      end
    end

    if (in_acc) begin
      pend_nxt     = 1'b1;
      pend_rdy_nxt = in_ch.tx_ready;
      if (in_ch.kind == KIND_TICK) begin
        if (milli_inc == cfg.ticks) begin
          milli_nxt     = '0;
          sec_total_nxt = sec_total_r + 1'b1;
        end else begin
          milli_nxt = milli_inc;
        end
      end else if ((in_ch.dest_port == cfg.port) && (in_ch.reply_seconds != '0)) begin
        offset_nxt    = in_ch.reply_seconds - sec_total_r;
        next_sync_nxt = sec_total_r + cfg.resync;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      milli_r     <= '0;
      sec_total_r <= '0;
      next_sync_r <= '0;
      offset_r    <= '0;
      next_ref_r  <= '0;
      pend_r      <= 1'b0;
      pend_rdy_r  <= 1'b0;
    end else begin
      milli_r     <= milli_nxt;
      sec_total_r <= sec_total_nxt;
      next_sync_r <= next_sync_nxt;
      offset_r    <= offset_nxt;
      next_ref_r  <= next_ref_nxt;
      pend_r      <= pend_nxt;
      pend_rdy_r  <= pend_rdy_nxt;
    end
  end

endmodule

/* hdl/nscs_fifo.sv */
// ----------------------------------------------------------------------------
// nscs_fifo
// Short job queue between front and back; registers, head read.
// ----------------------------------------------------------------------------
module nscs_fifo import nscs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  nscs_job_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output nscs_job_t head_data
);

  nscs_job_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/nscs_back.sv */
// ----------------------------------------------------------------------------
// nscs_back
// Pops jobs, emits request and refresh results, converts local seconds
// into hours, minutes and seconds with one shared reciprocal multiplier.
// ----------------------------------------------------------------------------
module nscs_back import nscs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  nscs_cfg_t  cfg,
  input  logic       head_valid,
  input  nscs_job_t  head_data,
  output logic       pop,
  nscs_out_if.source out_ch
);

  nscs_bk_state_t      st_r, st_nxt;
  nscs_step_t          step_r, step_nxt;
  logic                refr_r, refr_nxt;
  logic [SEC_W-1:0]    val_r, val_nxt;
  logic [2*SEC_W-1:0]  prod_r, prod_nxt;
  logic [MIN_W-1:0]    sec_r, sec_nxt;
  logic [MIN_W-1:0]    min_r, min_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [HOUR_W-1:0]   out_h_r, out_h_nxt;
  logic [MIN_W-1:0]    out_m_r, out_m_nxt;
  logic [MIN_W-1:0]    out_s_r, out_s_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_free;

  logic [SEC_W-1:0]    mul_a;
  logic [SEC_W-1:0]    mul_b;
  logic [26:0]         q60;
  logic [6:0]          q60_lo;
  logic [6:0]          rem60;
  logic [SEC_W-1:0]    q3;
  logic [2:0]          q3_lo;
  logic [2:0]          rem3;

  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = out_kind_r;
  assign out_ch.request_address = out_addr_r;
  assign out_ch.hours           = out_h_r;
  assign out_ch.minutes         = out_m_r;
  assign out_ch.seconds         = out_s_r;
  assign out_ch.last            = out_last_r;

  // Shared multiplier operands: by 60 twice, then by 3 on hours / 8
  assign mul_a = (step_r == STEP_HOUR) ? {3'b000, val_r[SEC_W-1:3]} : val_r;
  assign mul_b = (step_r == STEP_HOUR) ? DIV3_MUL : DIV60_MUL;

  // Quotient estimate is exact or one low; the remainder fixes it
  assign q60    = prod_r[2*SEC_W-1:DIV60_SHIFT];
  assign q60_lo = 7'(q60[6:0] * SIXTY);
  assign rem60  = val_r[6:0] - q60_lo;
  assign q3     = prod_r[2*SEC_W-1:DIV3_SHIFT];
  assign q3_lo  = 3'(q3[2:0] * THREE);
  assign rem3   = val_r[5:3] - q3_lo;

  always_comb begin
    st_nxt        = st_r;
    step_nxt      = step_r;
    refr_nxt      = refr_r;
    val_nxt       = val_r;
    prod_nxt      = prod_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_h_nxt     = out_h_r;
    out_m_nxt     = out_m_r;
    out_s_nxt     = out_s_r;
    out_last_nxt  = out_last_r;

    case (st_r)
      BK_IDLE: begin
        if (head_valid) begin
          pop      = 1'b1;
          refr_nxt = head_data.refr;
          val_nxt  = head_data.lt;
          step_nxt = STEP_SEC;
          st_nxt   = head_data.req ? BK_REQ : BK_MUL;
        end
      end
      BK_REQ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RES_REQUEST;
          out_addr_nxt  = cfg.server;
          out_h_nxt     = '0;
          out_m_nxt     = '0;
          out_s_nxt     = '0;
          out_last_nxt  = !refr_r;
          st_nxt        = refr_r ? BK_MUL : BK_IDLE;
        end
      end
      BK_MUL: begin
        prod_nxt = 64'(mul_a) * 64'(mul_b);
        st_nxt   = BK_COR;
      end
      BK_COR: begin
        if (step_r == STEP_HOUR) begin
          hour_nxt = {((rem3 >= THREE) ? 2'(rem3 - THREE) : rem3[1:0]), val_r[2:0]};
          st_nxt   = BK_REF;
        end else begin
          if (rem60 >= SIXTY) begin
            val_nxt = SEC_W'(q60) + 1'b1;
            if (step_r == STEP_SEC) sec_nxt = 6'(rem60 - SIXTY);
            else                    min_nxt = 6'(rem60 - SIXTY);
          end else begin
            val_nxt = SEC_W'(q60);
            if (step_r == STEP_SEC) sec_nxt = rem60[5:0];
            else                    min_nxt = rem60[5:0];
          end
          step_nxt = (step_r == STEP_SEC) ? STEP_MIN : STEP_HOUR;
          st_nxt   = BK_MUL;
        end
      end
      BK_REF: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RES_REFRESH;
          out_addr_nxt  = '0;
          out_h_nxt     = hour_r;
          out_m_nxt     = min_r;
          out_s_nxt     = sec_r;
          out_last_nxt  = 1'b1;
          st_nxt        = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      step_r      <= STEP_SEC;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk) begin
    refr_r     <= refr_nxt;
    val_r      <= val_nxt;
    prod_r     <= prod_nxt;
    sec_r      <= sec_nxt;
    min_r      <= min_nxt;
    hour_r     <= hour_nxt;
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_h_r    <= out_h_nxt;
    out_m_r    <= out_m_nxt;
    out_s_r    <= out_s_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

/* hdl/network_synced_clock_scheduler_core.sv */
// ----------------------------------------------------------------------------
// network_synced_clock_scheduler_core
// Millisecond time base kept in step with a network time server.
//
// in_ch carries millisecond ticks and parsed time replies (valid/ready).
// out_ch carries time requests and local-time refreshes; last marks the
// final result of an input item. cfg_we/cfg_idx/cfg_wdata write the
// registers; the user writes them only while the block is idle, which
// the block itself does not enforce. The front takes one item per cycle
// unless it stalls, and evaluates it the cycle after unless the queue is
// full; a four-entry job queue feeds the back. A request passes the
// pending register, the queue and the back's request state; a refresh,
// after the request when both are due, takes the three multiply and
// correct steps of the hours/minutes/seconds conversion on one shared
// multiplier. The back finishes one job before it pops the next.
// Reset clears the time base, the schedule (a sync is due at once) and
// the offset, and loads the register defaults. When out_ch stalls, the
// result register holds, jobs collect in the queue, and in_ch.ready
// drops once the queue is full and the pending item has results.
// ----------------------------------------------------------------------------
module network_synced_clock_scheduler_core import nscs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  nscs_in_if.sink               in_ch,
  nscs_out_if.source            out_ch
);

  nscs_cfg_t cfg_r, cfg_nxt;
  nscs_job_t job;
  nscs_job_t head_data;
  logic      job_push;
  logic      q_full;
  logic      head_valid;
  logic      pop;

  // Register writes; zone kept as seconds
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_TICKS:     cfg_nxt.ticks     = cfg_wdata[TPS_W-1:0];
        CFG_ZONE:      cfg_nxt.zone_secs = zone_to_secs(cfg_wdata[ZONE_W-1:0]);
        CFG_RESYNC:    cfg_nxt.resync    = cfg_wdata[SEC_W-1:0];
        CFG_RETRY:     cfg_nxt.retry     = cfg_wdata[WAIT_W-1:0];
        CFG_SENT_WAIT: cfg_nxt.sent_wait = cfg_wdata[WAIT_W-1:0];
        CFG_SERVER:    cfg_nxt.server    = cfg_wdata[ADDR_W-1:0];
        CFG_PORT:      cfg_nxt.port      = cfg_wdata[PORT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks     <= RST_TICKS;
      cfg_r.zone_secs <= zone_to_secs(RST_ZONE);
      cfg_r.resync    <= RST_RESYNC;
      cfg_r.retry     <= RST_RETRY;
      cfg_r.sent_wait <= RST_SENT_WAIT;
      cfg_r.server    <= RST_SERVER;
      cfg_r.port      <= RST_PORT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nscs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (job)
  );

  nscs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  nscs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // Input stalls only when the queue is full
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_full)
    else $error("input stalled while the job queue has room");

  // Queue never takes a job while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !q_full)
    else $error("job pushed into a full queue");

  // Converted local time stays in range
  a_refresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.result_kind == RES_REFRESH)) |->
      ((out_ch.hours < 5'd24) && (out_ch.minutes < 6'd60) && (out_ch.seconds < 6'd60)
       && out_ch.last))
    else $error("refresh result out of range");

  // A request that is not last is followed by its refresh within the conversion time
  a_req_then_ref: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && (out_ch.result_kind == RES_REQUEST)
     && !out_ch.last) |-> ##[1:7] (out_ch.valid && (out_ch.result_kind == RES_REFRESH)))
    else $error("request not followed by its refresh");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the network-synced clock scheduler core. A short
// table of directed transactions covers the reset registers, the field
// extremes, rejected replies and the request/refresh ordering. Random phases
// follow, each with its own register setting, and drive ticks and time
// replies in bursts while the result side stalls on its own pattern. A
// scoreboard model of the time base predicts every request and refresh, and
// each result is compared in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nscs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 3'd7;   // unused register index
  localparam logic [1:0]           PREDICTED = 2'd3;   // row checked by the model
  localparam int DRAIN     = 30;
  localparam int LONG_HOLD = 300;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic              kind;
    logic [PORT_W-1:0] dest_port;
    logic [SEC_W-1:0]  reply_seconds;
    logic              tx_ready;
  } sync_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] request_address;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [MIN_W-1:0]  seconds;
    logic              last;
  } sync_result_t;

  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    sync_item_t            item;
    logic [1:0]            n_typed;
    sync_result_t          typed;
  } stim_row_t;

  typedef enum int {SINK_OPEN, SINK_3_OF_4, SINK_COIN, SINK_1_OF_5} sink_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nscs_in_if  in_ch ();
  nscs_out_if out_ch ();

  network_synced_clock_scheduler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies, loaded with the reset values
  logic [TPS_W-1:0]  tps_reg       = RST_TICKS;
  logic [ZONE_W-1:0] zone_reg      = RST_ZONE;
  logic [SEC_W-1:0]  resync_reg    = RST_RESYNC;
  logic [WAIT_W-1:0] retry_reg     = RST_RETRY;
  logic [WAIT_W-1:0] sent_wait_reg = RST_SENT_WAIT;
  logic [ADDR_W-1:0] server_reg    = RST_SERVER;
  logic [PORT_W-1:0] port_reg      = RST_PORT;

  // Time base and schedule as the block should hold them
  logic [TPS_W-1:0] milli_model  = '0;
  logic [SEC_W-1:0] sec_count    = '0;
  logic [SEC_W-1:0] sync_due     = '0;
  logic [SEC_W-1:0] offset_model = '0;
  logic [SEC_W-1:0] refresh_due  = '0;

  sync_result_t pending_results [$];
  stim_row_t    stim_table [$];

  int  error_count   = 0;
  int  items_sent    = 0;
  int  requests_seen = 0;
  int  refresh_seen  = 0;
  int  setting_count = 0;
  bit  hold_request  = 1'b0;

  sync_result_t got_res;

  // --------------------------------------------------------------------------
  // Time base model: one accepted transaction in, up to two results out
  // --------------------------------------------------------------------------
  function automatic int advance_clock(input sync_item_t it, output sync_result_t res [2]);
    logic [SEC_W-1:0] zone_secs;
    logic [SEC_W-1:0] local_secs;
    int n;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (it.kind == KIND_TICK) begin
      milli_model = milli_model + 1'b1;
      if (milli_model == tps_reg) begin
        sec_count   = sec_count + 1'b1;
        milli_model = '0;
      end
    end else if (it.dest_port == port_reg && it.reply_seconds != '0) begin
      offset_model = it.reply_seconds - sec_count;
      sync_due     = sec_count + resync_reg;
    end
    // a due sync is requested first; tx_ready only picks the next wait
    if (sec_count >= sync_due) begin
      res[n].result_kind     = RES_REQUEST;
      res[n].request_address = server_reg;
      n++;
      sync_due = sec_count + (it.tx_ready ? sent_wait_reg : retry_reg);
    end
    // refresh at most once per second, only once the time is known
    if (offset_model != '0 && sec_count >= refresh_due) begin
      zone_secs   = {{(SEC_W-ZONE_W){zone_reg[ZONE_W-1]}}, zone_reg} * 32'd3600;
      local_secs  = offset_model + sec_count + zone_secs;
      refresh_due = sec_count + 1'b1;
      res[n].result_kind = RES_REFRESH;
      res[n].hours       = HOUR_W'((local_secs / 3600) % 24);
      res[n].minutes     = MIN_W'((local_secs / 60) % 60);
      res[n].seconds     = MIN_W'(local_secs % 60);
      n++;
    end
    if (n > 0) res[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic void flag_error(input string what, input sync_result_t want,
                                     input sync_result_t got);
    error_count++;
    if (error_count <= MAX_SHOWN)
      $display({"ERROR %s: exp kind=%0d addr=%h %0d:%0d:%0d last=%0d",
                " | got kind=%0d addr=%h %0d:%0d:%0d last=%0d"},
               what, want.result_kind, want.request_address, want.hours, want.minutes,
               want.seconds, want.last, got.result_kind, got.request_address, got.hours,
               got.minutes, got.seconds, got.last);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_res = {out_ch.result_kind, out_ch.request_address, out_ch.hours,
                 out_ch.minutes, out_ch.seconds, out_ch.last};
      if (pending_results.size() == 0) begin
        flag_error("result with none pending", '0, got_res);
      end else begin
        if (got_res !== pending_results[0])
          flag_error("result mismatch", pending_results[0], got_res);
        if (pending_results[0].result_kind == RES_REQUEST) requests_seen++;
        else refresh_seen++;
        void'(pending_results.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: changing stall patterns plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_t mode;
    int mode_left;
    int hold_left;
    int cyc;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    cyc       = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(3));
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_3_OF_4: out_ch.ready <= (cyc % 4) != 0;
          SINK_COIN:   out_ch.ready <= 1'($urandom_range(1));
          default:     out_ch.ready <= (cyc % 5) == 0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input logic kind, input logic [PORT_W-1:0] port,
                          input logic [SEC_W-1:0] secs, input logic txr,
                          input logic [1:0] n_typed, input sync_result_t typed);
    stim_row_t row;
    row         = '0;
    row.item    = {kind, port, secs, txr};
    row.n_typed = n_typed;
    row.typed   = typed;
    stim_table.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    stim_table.push_back(row);
  endtask

  // Offer one transaction, wait for it to be taken, then queue its results
  task automatic offer(input sync_item_t it, input logic [1:0] n_typed,
                       input sync_result_t typed);
    sync_result_t produced [2];
    int n;
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= it.kind;
    in_ch.dest_port     <= it.dest_port;
    in_ch.reply_seconds <= it.reply_seconds;
    in_ch.tx_ready      <= it.tx_ready;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
    n = advance_clock(it, produced);
    if (n_typed == PREDICTED) begin
      for (int k = 0; k < n; k++) pending_results.push_back(produced[k]);
    end else if (n_typed != 2'd0) begin
      pending_results.push_back(typed);
    end
  endtask

  // Drop valid, wait for every pending result, then let the back end drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_TICKS:     tps_reg       = data[TPS_W-1:0];
      CFG_ZONE:      zone_reg      = data[ZONE_W-1:0];
      CFG_RESYNC:    resync_reg    = data[SEC_W-1:0];
      CFG_RETRY:     retry_reg     = data[WAIT_W-1:0];
      CFG_SENT_WAIT: sent_wait_reg = data[WAIT_W-1:0];
      CFG_SERVER:    server_reg    = data[ADDR_W-1:0];
      CFG_PORT:      port_reg      = data[PORT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [TPS_W-1:0] tps, input logic [ZONE_W-1:0] zone,
                               input logic [SEC_W-1:0] resync, input logic [WAIT_W-1:0] retry,
                               input logic [WAIT_W-1:0] sent_wait,
                               input logic [ADDR_W-1:0] server, input logic [PORT_W-1:0] port);
    settle();
    write_reg(CFG_TICKS,     CFG_DATA_W'(tps));
    write_reg(CFG_ZONE,      CFG_DATA_W'(zone));
    write_reg(CFG_RESYNC,    resync);
    write_reg(CFG_RETRY,     CFG_DATA_W'(retry));
    write_reg(CFG_SENT_WAIT, CFG_DATA_W'(sent_wait));
    write_reg(CFG_SERVER,    server);
    write_reg(CFG_PORT,      CFG_DATA_W'(port));
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // Random ticks and replies in bursts; replies are mostly well formed
  task automatic run_random(input int count, input int tick_pct, input bit until_rollover);
    sync_item_t it;
    logic [SEC_W-1:0] start_sec;
    int sent;
    int burst;
    int gap;
    int tail;
    start_sec = sec_count;
    sent      = 0;
    burst     = 0;
    tail      = 20;
    while (sent < count) begin
      if (until_rollover && sec_count != start_sec) begin
        if (tail == 0) break;
        tail--;
      end
      if (burst == 0) begin
        burst = $urandom_range(40, 1);
        gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      it.kind          = ($urandom_range(99) < tick_pct) ? KIND_TICK : KIND_REPLY;
      it.dest_port     = PORT_W'($urandom);
      it.reply_seconds = $urandom;
      it.tx_ready      = 1'($urandom_range(1));
      if (it.kind == KIND_REPLY) begin
        it.dest_port = port_reg;
        case ($urandom_range(9))
          0: it.dest_port     = port_reg + PORT_W'($urandom_range(65535, 1));
          1: it.reply_seconds = '0;
          2: it.reply_seconds = sec_count;             // offset back to zero
          3: it.reply_seconds = 32'hFFFF_FFFF - $urandom_range(100);
          4: it.reply_seconds = $urandom_range(100, 1);
          default: ;
        endcase
      end
      offer(it, PREDICTED, '0);
      sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_TICK;
    in_ch.dest_port     <= '0;
    in_ch.reply_seconds <= '0;
    in_ch.tx_ready      <= 1'b0;

    // Reset registers: sync due at once, time unknown
    add_item(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 2'd1,
             '{RES_REQUEST, RST_SERVER, 5'd0, 6'd0, 6'd0, 1'b1});
    add_item(KIND_REPLY, RST_PORT + 16'd1, 32'd5, 1'b1, 2'd0, '0);       // wrong port
    add_item(KIND_REPLY, RST_PORT, 32'd0, 1'b1, 2'd0, '0);               // zero seconds
    add_item(KIND_REPLY, 16'h0000, 32'hFFFF_FFFF, 1'b0, 2'd0, '0);
    // good reply: offset -1 plus zone 7 gives 06:59:59
    add_item(KIND_REPLY, RST_PORT, 32'hFFFF_FFFF, 1'b1, 2'd1,
             '{RES_REFRESH, 32'd0, 5'd6, 6'd59, 6'd59, 1'b1});
    add_item(KIND_REPLY, RST_PORT, 32'd1, 1'b0, 2'd0, '0);               // same second
    add_item(KIND_TICK, 16'h0000, 32'd0, 1'b1, 2'd0, '0);
    // unused index ignored; upper data bits dropped (3 ticks per second)
    add_cfg(CFG_NONE, 32'hFFFF_FFFF);
    add_cfg(CFG_TICKS, 32'hABCD_E403);
    add_cfg(CFG_RESYNC, 32'd2);
    add_item(KIND_TICK, 16'h1234, 32'h5555_AAAA, 1'b1, PREDICTED, '0);
    add_item(KIND_REPLY, RST_PORT, 32'h8000_0000, 1'b0, PREDICTED, '0);
    // request and refresh from one tick, request first
    for (int k = 0; k < 6; k++)
      add_item(KIND_TICK, 16'(k), 32'(k), 1'b0, PREDICTED, '0);
    // reply equal to the local count: offset zero, refreshes stop
    add_item(KIND_REPLY, RST_PORT, 32'd3, 1'b0, PREDICTED, '0);
    for (int k = 0; k < 6; k++)
      add_item(KIND_TICK, 16'hFFFF, 32'd0, 1'b1, PREDICTED, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.idx, row.data);
        cfg_we <= 1'b0;
      end else begin
        offer(row.item, row.n_typed, row.typed);
      end
    end

    // Fastest clock, all minimum waits; output held off while input keeps coming
    set_registers(10'd1, 5'(-12), 32'd1, 16'd1, 16'd1, 32'h0000_0000, 16'h0000);
    hold_request = 1'b1;
    run_random(150, 60, 1'b0);

    // Maximum waits and addresses; a huge resync wraps to a sync due at once
    set_registers(10'd3, 5'd14, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    run_random(150, 60, 1'b0);

    // Out-of-range zone, random schedule values
    set_registers(10'd2, 5'd15, $urandom, 16'($urandom_range(8, 1)),
                  16'($urandom_range(8, 1)), $urandom, 16'($urandom));
    run_random(150, 70, 1'b0);

    // Slowest legal rate, most negative zone code
    set_registers(10'd1023, 5'(-16), 32'd5, 16'd3, 16'd7, $urandom, 16'($urandom));
    run_random(100, 90, 1'b0);

    // Zero ticks per second below the running count: the count runs on
    set_registers(10'd0, RST_ZONE, 32'd3, 16'd1, 16'd2, $urandom, RST_PORT);
    run_random(150, 97, 1'b0);

    // Random legal setting
    set_registers(10'($urandom_range(6, 1)), 5'($urandom_range(26) - 12),
                  32'($urandom_range(20, 1)), 16'($urandom_range(5, 1)),
                  16'($urandom_range(5, 1)), $urandom, 16'($urandom));
    run_random(200, 65, 1'b0);

    settle();
    $display("Covered %0d input transactions over %0d register settings;", items_sent,
             setting_count);
    $display("%0d requests and %0d refreshes checked, %0d mismatches.", requests_seen,
             refresh_seen, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d results pending", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
